FILE: sv/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants of the sliding median filter: payload structs,
// the slot held by one rank cell and the control group driving the cell ring.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int HALF_W       = 3;
    localparam int DEF_MAX_HALF = 4;

    localparam logic [HALF_W-1:0] HALF_RESET = 3'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    block_end;
    } smf_in_t;

    typedef struct packed {
        sample_t filtered;
        logic    final_res;
    } smf_out_t;

    // one window entry as it travels round the rank ring
    typedef struct packed {
        sample_t value;
        logic    active;
    } smf_slot_t;

    typedef struct packed {
        logic load;
        logic rotate;
    } smf_ring_ctl_t;

endpackage

FILE: sv/smf_tap_cell.sv
// ----------------------------------------------------------------------------
// smf_tap_cell
// One stage of the sample delay line; takes its neighbour's sample on every
// input transfer, so stage j holds the sample j steps older than the newest.
// ----------------------------------------------------------------------------
module smf_tap_cell
    import smf_pkg::*;
(
    input  logic    clk,
    input  logic    shift,
    input  sample_t shift_in,
    output sample_t tap
);

    sample_t tap_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            tap_reg <= shift_in;
        end
    end

    assign tap = tap_reg;

endmodule

FILE: sv/smf_rank_cell.sv
// ----------------------------------------------------------------------------
// smf_rank_cell
// One cell of the rank ring. Loads a window entry, hands it to its neighbour
// while the ring rotates, and compares it with the candidate in cell zero.
// ----------------------------------------------------------------------------
module smf_rank_cell
    import smf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  smf_ring_ctl_t ctl,
    input  smf_slot_t     load_slot,
    input  smf_slot_t     from_next,
    input  sample_t       cand,
    output smf_slot_t     slot,
    output logic          below,
    output logic          not_above
);

    smf_slot_t slot_reg;
    smf_slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.load)
        begin
            slot_next = load_slot;
        end
        else if (ctl.rotate)
        begin
            slot_next = from_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot      = slot_reg;
    assign below     = slot_reg.active && (slot_reg.value < cand);
    assign not_above = slot_reg.active && (slot_reg.value <= cand);

endmodule

FILE: sv/sliding_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_median_filter
// Running median over blocks of signed samples, window of 2k+1 samples.
// ----------------------------------------------------------------------------
// Samples of a block enter one per transfer, the last one marked by block_end.
// Each result is the median of the 2k+1 samples centred on one block position;
// window places outside the block take the centre sample. Results lag the
// input by k samples and the block_end sample flushes up to k+1 results, the
// last one marked by final_res. A new sample is taken only while the block is
// idle. Each result is loaded into the rank ring, searched for by rotating the
// ring and then moved into the output register, waiting while the output
// register is stalled. The rank search rotates the window at most once round
// a ring of 2*MAX_HALF+1 cells and stops when at most k entries lie below the
// entry in cell zero and more than k lie at or below it. half_width is clamped
// to 1..MAX_HALF and must be written only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_median_filter
    import smf_pkg::*;
#(
    parameter int MAX_HALF = DEF_MAX_HALF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  smf_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output smf_out_t          out_data,
    input  logic              cfg_wr_en,
    input  logic [HALF_W-1:0] cfg_wr_data
);

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int K_W   = $clog2(MAX_HALF + 1);
    localparam int CMP_W = (K_W > HALF_W) ? K_W : HALF_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RANK = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [HALF_W-1:0] half_width_reg, half_width_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [K_W-1:0]    c_reg, c_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;

    sample_t           centre_reg;
    logic [CNT_W-1:0]  copies_reg;
    sample_t           med_reg;
    smf_out_t          out_reg;

    sample_t           tap [DEPTH];
    smf_slot_t         load_slot [DEPTH];
    smf_slot_t         slot [DEPTH];
    logic [DEPTH-1:0]  load_act;
    logic [DEPTH-1:0]  below_vec;
    logic [DEPTH-1:0]  not_above_vec;
    smf_ring_ctl_t     ring_ctl;
    sample_t           cand;

    logic              in_xfer;
    logic              out_free;
    logic [CMP_W-1:0]  hw_ext;
    logic [K_W-1:0]    k_eff;
    logic [CNT_W-1:0]  seen_inc;
    logic [CNT_W-1:0]  seen_dec;
    logic [K_W-1:0]    top_c;
    logic              has_result;
    logic [CNT_W-1:0]  load_cnt;
    logic [CNT_W-1:0]  below_cnt;
    logic [CNT_W-1:0]  upto_cnt;
    logic              found;

    assign in_xfer  = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // clamp of the written half width
    always_comb
    begin
        hw_ext = CMP_W'(half_width_reg);
        if (hw_ext == '0)
        begin
            k_eff = K_W'(1);
        end
        else if (hw_ext > CMP_W'(MAX_HALF))
        begin
            k_eff = K_W'(MAX_HALF);
        end
        else
        begin
            k_eff = K_W'(hw_ext);
        end
    end

    assign seen_inc   = (seen_reg == CNT_W'(DEPTH)) ? seen_reg : CNT_W'(seen_reg + 1'b1);
    assign seen_dec   = CNT_W'(seen_inc - 1'b1);
    assign top_c      = (seen_dec < CNT_W'(k_eff)) ? K_W'(seen_dec) : k_eff;
    assign has_result = in_data.block_end || (seen_inc > CNT_W'(k_eff));

    // delay line of samples
    generate
        for (genvar j = 0; j < DEPTH; j++)
        begin : g_tap
            smf_tap_cell u_tap
            (
                .clk      (clk),
                .shift    (in_xfer),
                .shift_in ((j == 0) ? in_data.sample : tap[(j == 0) ? 0 : j - 1]),
                .tap      (tap[j])
            );
        end
    endgenerate

    assign ring_ctl.load   = (state_reg == ST_LOAD);
    assign ring_ctl.rotate = (state_reg == ST_RANK);
    assign cand            = slot[0].value;

    // ring of rank cells; cell j loads the sample of age j and passes left
    generate
        for (genvar j = 0; j < DEPTH; j++)
        begin : g_rank
            assign load_act[j] = (CNT_W'(j) < seen_reg)
                              && (CNT_W'(j) <= CNT_W'(CNT_W'(c_reg) + CNT_W'(k_reg)));
            assign load_slot[j].value  = tap[j];
            assign load_slot[j].active = load_act[j];

            smf_rank_cell u_rank
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ring_ctl),
                .load_slot (load_slot[j]),
                .from_next (slot[(j + 1) % DEPTH]),
                .cand      (cand),
                .slot      (slot[j]),
                .below     (below_vec[j]),
                .not_above (not_above_vec[j])
            );
        end
    endgenerate

    // window places outside the block count as extra copies of the centre
    always_comb
    begin
        load_cnt  = '0;
        below_cnt = '0;
        upto_cnt  = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            load_cnt  = CNT_W'(load_cnt + CNT_W'(load_act[j]));
            below_cnt = CNT_W'(below_cnt + CNT_W'(below_vec[j]));
            upto_cnt  = CNT_W'(upto_cnt + CNT_W'(not_above_vec[j]));
        end
        if (centre_reg < cand)
        begin
            below_cnt = CNT_W'(below_cnt + copies_reg);
        end
        if (centre_reg <= cand)
        begin
            upto_cnt = CNT_W'(upto_cnt + copies_reg);
        end
    end

    assign found = slot[0].active
                && (below_cnt <= CNT_W'(k_reg))
                && (upto_cnt > CNT_W'(k_reg));

    always_comb
    begin
        state_next      = state_reg;
        half_width_next = half_width_reg;
        seen_next       = seen_reg;
        k_next          = k_reg;
        c_next          = c_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;

        if (cfg_wr_en)
        begin
            half_width_next = cfg_wr_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    seen_next = seen_inc;
                    k_next    = k_eff;
                    last_next = in_data.block_end;
                    c_next    = in_data.block_end ? top_c : k_eff;
                    if (has_result)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RANK;
            end
            ST_RANK:
            begin
                if (found)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (last_reg && (c_reg != '0))
                    begin
                        c_next     = K_W'(c_reg - 1'b1);
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        if (last_reg)
                        begin
                            seen_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            half_width_reg <= HALF_RESET;
            seen_reg       <= '0;
            k_reg          <= '0;
            c_reg          <= '0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            half_width_reg <= half_width_next;
            seen_reg       <= seen_next;
            k_reg          <= k_next;
            c_reg          <= c_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            centre_reg <= tap[IDX_W'(c_reg)];
            copies_reg <= CNT_W'(CNT_W'({k_reg, 1'b1}) - load_cnt);
        end
        if ((state_reg == ST_RANK) && found)
        begin
            med_reg <= cand;
        end
        if ((state_reg == ST_PUSH) && out_free)
        begin
            out_reg.filtered  <= med_reg;
            out_reg.final_res <= last_reg && (c_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: sv/smf_checker.sv
// ----------------------------------------------------------------------------
// smf_checker
// Port-level checks of the sliding median filter, bound to the top level.
// ----------------------------------------------------------------------------
module smf_checker
    import smf_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input smf_in_t  in_data,
    input logic     out_valid,
    input logic     out_ready,
    input smf_out_t out_data
);

    // a block_end transfer whose closing result has not shown yet
    logic pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (in_valid && in_ready && in_data.block_end)
        begin
            pending_reg <= 1'b1;
        end
        else if (out_valid && out_data.final_res)
        begin
            pending_reg <= 1'b0;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input side closed without an input transfer");

    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the block was idle");

    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !pending_reg || (out_valid && out_data.final_res))
        else $error("new block taken before the previous block was flushed");

endmodule

bind sliding_median_filter smf_checker u_smf_checker (.*);

FILE: sim/tb_sliding_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_median_filter
// Self-checking bench for the running median filter: a queue-fed driver and a
// monitor that predicts every median from its own window ring and compares
// each output transfer in order, across several half widths and idle mixes.
// ----------------------------------------------------------------------------
module tb_sliding_median_filter;
    import smf_pkg::*;

    localparam int MAXH   = DEF_MAX_HALF;
    localparam int RING   = 2 * MAXH + 1;
    // settling wait after the queues drain, for a block_end item flushing k+1 results
    localparam int SETTLE = (MAXH + 1) * (2 * MAXH + 3) + 5;

    typedef enum int {FULL_RANGE, CLUSTERED, EXTREMES} sample_mix_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    smf_in_t           in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    smf_out_t          out_data;
    logic              cfg_wr_en = 1'b0;
    logic [HALF_W-1:0] cfg_wr_data = '0;

    logic              in_fire = 1'b0;
    int                send_idle_pct = 16;
    int                recv_idle_pct = 62;
    int                mismatches = 0;

    smf_in_t           feed_q[$];
    smf_out_t          median_q[$];

    // predictor state
    sample_t           ring [RING] = '{default: '0};
    int                seen = 0;
    int                slot = 0;
    logic [HALF_W-1:0] half_cfg = HALF_RESET;

    sliding_median_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic sample_t ring_age(int age);
        return ring[(slot + 2 * RING - 1 - age) % RING];
    endfunction

    function automatic sample_t window_median(int c, int k);
        sample_t win [RING];
        sample_t centre;
        sample_t v;
        int      i;
        int      j;
        int      age;
        centre = ring_age(c);
        for (i = 0; i < 2 * k + 1; i++)
        begin
            age = c + k - i;
            // places outside the block take the centre sample
            if (age < 0 || age >= seen)
                win[i] = centre;
            else
                win[i] = ring_age(age);
        end
        for (i = 1; i < 2 * k + 1; i++)
        begin
            v = win[i];
            j = i;
            while (j > 0 && win[j-1] > v)
            begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = v;
        end
        return win[k];
    endfunction

    function automatic void predict_medians(smf_in_t item);
        int       k;
        int       top;
        int       c;
        smf_out_t res;
        k = (half_cfg < 1) ? 1 : (half_cfg > MAXH) ? MAXH : int'(half_cfg);
        ring[slot] = item.sample;
        slot = (slot + 1) % RING;
        if (seen < RING)
            seen++;
        if (!item.block_end)
        begin
            if (seen > k)
            begin
                res.filtered  = window_median(k, k);
                res.final_res = 1'b0;
                median_q.push_back(res);
            end
        end
        else
        begin
            // flush every position still pending, oldest first
            top = (seen - 1 < k) ? seen - 1 : k;
            for (c = top; c >= 0; c--)
            begin
                res.filtered  = window_median(c, k);
                res.final_res = (c == 0);
                median_q.push_back(res);
            end
            seen = 0;
            slot = 0;
        end
    endfunction

    function automatic void check_median(smf_out_t got);
        smf_out_t want;
        if (median_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: filtered %0d final_res %0b",
                         got.filtered, got.final_res);
        end
        else
        begin
            want = median_q.pop_front();
            if (got.filtered !== want.filtered || got.final_res !== want.final_res)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected filtered %0d final_res %0b, got %0d %0b",
                             want.filtered, want.final_res, got.filtered, got.final_res);
            end
        end
    endfunction

    // monitor
    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_medians(in_data);
            if (out_valid && out_ready)
                check_median(out_data);
        end
    end

    // driver
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!in_valid || in_fire)
        begin
            if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data  <= feed_q.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic push_sample(sample_t s, logic last);
        smf_in_t item;
        item.sample    = s;
        item.block_end = last;
        feed_q.push_back(item);
    endtask

    function automatic sample_t draw_sample(sample_mix_t mix);
        sample_t edges [7] = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1,
                               16'sh7ffe, 16'sh7fff};
        case (mix)
            CLUSTERED: return sample_t'(int'($urandom_range(0, 6)) - 3);
            EXTREMES:  return edges[$urandom_range(6)];
            default:   return sample_t'($urandom);
        endcase
    endfunction

    // random blocks, mostly short with the odd long one
    task automatic queue_blocks(int items);
        int          count;
        int          len;
        int          i;
        sample_mix_t mix;
        count = 0;
        while (count < items)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 12);
            mix = sample_mix_t'($urandom_range(2));
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(3) == 0)
                    push_sample(draw_sample(sample_mix_t'($urandom_range(2))), i == len - 1);
                else
                    push_sample(draw_sample(mix), i == len - 1);
            end
            count += len;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (feed_q.size() != 0 || in_valid || median_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_half(logic [HALF_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        half_cfg     = v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [HALF_W-1:0] phase_half [6];
        int                p;
        int                i;
        phase_half = '{3'd1, 3'd4, 3'd3, 3'd6, 3'd5, 3'd2};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset half width: single-sample block, short block, extremes
        push_sample(16'sh7fff, 1'b1);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b1);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd1, 1'b1);
        wait_idle();

        // zero half width acts as one
        write_half(3'd0);
        push_sample(16'sd5, 1'b0);
        push_sample(-16'sd5, 1'b0);
        push_sample(16'sd5, 1'b1);
        wait_idle();

        // above the maximum clamps; long enough to wrap the ring
        write_half(3'd7);
        for (i = 0; i < 10; i++)
            push_sample(sample_t'((i * 24593) ^ 16'h5a5a), i == 9);
        wait_idle();

        // half width changed partway through a block
        write_half(3'd4);
        for (i = 0; i < 5; i++)
            push_sample(sample_t'(i * 9000 - 20000), 1'b0);
        wait_idle();
        write_half(3'd1);
        push_sample(16'sh4000, 1'b0);
        push_sample(-16'sd300, 1'b0);
        push_sample(16'sd77, 1'b1);
        wait_idle();

        for (p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 16;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_half(phase_half[p]);
            queue_blocks(49);
            wait_idle();
        end

        if (mismatches == 0 && median_q.size() == 0)
            $display("PASS sliding_median_filter");
        else
            $display("FAIL sliding_median_filter");
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("FAIL sliding_median_filter");
        $finish;
    end

endmodule

FILE: files.f
sv/smf_pkg.sv
sv/smf_tap_cell.sv
sv/smf_rank_cell.sv
sv/sliding_median_filter.sv
sv/smf_checker.sv
sim/tb_sliding_median_filter.sv
